// File: hdl/fxa_pkg.sv
// Package for the Q24.8 fixed-point ALU: opcodes, status codes, widths,
// and the per-stage pipeline word types. No dependencies.
`default_nettype none
package fxa_pkg;
   localparam int WordBits = 32;
   localparam int FracBits = 8;
   localparam int NumBits  = WordBits + FracBits;   // divider numerator width
   localparam int Stages   = NumBits;                // one quotient bit per stage

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
      OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
      OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_SAT = 2'd1, ST_DIVZ = 2'd2
   } status_type;

   typedef struct packed {
      logic                        valid;
      opcode_type                  opcode;
      logic signed [WordBits-1:0]  a;
      logic signed [WordBits-1:0]  b;
   } item_type;

   typedef struct packed {
      logic                        valid;
      logic signed [WordBits-1:0]  value;
      logic                        cmp;
      status_type                  status;
   } result_type;

   // Clamp a wide signed value to the word range.
   function automatic logic [WordBits:0] clamp_word(input logic signed [2*WordBits+1:0] v);
      logic signed [2*WordBits+1:0] maxv;
      logic signed [2*WordBits+1:0] minv;
      maxv = (2*WordBits+2)'((64'sd1 <<< (WordBits-1)) - 64'sd1);
      minv = -maxv - (2*WordBits+2)'(1);
      if (v > maxv) clamp_word = {1'b1, maxv[WordBits-1:0]};
      else if (v < minv) clamp_word = {1'b1, minv[WordBits-1:0]};
      else clamp_word = {1'b0, v[WordBits-1:0]};
   endfunction
endpackage
`default_nettype wire

// File: hdl/fixed_point_q8_alu_core.sv
// Q24.8 fixed-point ALU top level.
// Every opcode takes the same path: the input register, the side pipe aligned with the
// bit-per-stage divider, and the output register that drives the rsp_ ports.
// Throughput: one word per cycle, start accepted whenever busy is low.
// busy is tied low; the receiver cannot stall. Reset clears the valid pipe.
// Depends on fxa_pkg, fxa_simple, fxa_mul, fxa_div_stage.
`default_nettype none
module fixed_point_q8_alu_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire logic [3:0]  req_opcode,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic      rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic      rsp_compare_true,
   output logic [1:0] rsp_status_code
);
   import fxa_pkg::*;
   localparam int Lat = Stages;

   item_type item_in, item_ff;
   result_type simple_res;
   logic [WordBits:0] mul_sat;
   logic [Lat-1:0] valid_ff;
   opcode_type op_pipe_ff [Lat];
   logic [1:0] sign_pipe_ff [Lat]; // {quotient negative, divide by zero}
   result_type sres_pipe_ff [Lat];
   logic [WordBits:0] mul_pipe_ff [Lat];

   logic [NumBits-1:0] num [Stages+1];
   logic [WordBits:0] rem [Stages+1];
   logic [WordBits-1:0] den [Stages+1];

   assign busy = 1'b0;

   always_comb begin
      item_in.valid = start & ~busy;
      item_in.opcode = opcode_type'(req_opcode);
      item_in.a = req_operand_a;
      item_in.b = req_operand_b;
   end

   always_ff @(posedge clock) begin
      if (reset) item_ff.valid <= 1'b0;
      else item_ff.valid <= item_in.valid;
      item_ff.opcode <= item_in.opcode;
      item_ff.a <= item_in.a;
      item_ff.b <= item_in.b;
   end

   fxa_simple u_simple (.clock(clock), .in_item(item_ff), .out_res(simple_res));
   fxa_mul u_mul (.clock(clock), .a(item_ff.a), .b(item_ff.b), .sat_value(mul_sat));

   // divider entry: magnitudes
   always_comb begin
      logic [WordBits-1:0] ma;
      ma = item_ff.a[WordBits-1] ? WordBits'(-item_ff.a) : item_ff.a;
      num[0] = {ma, FracBits'(0)};
      rem[0] = '0;
      den[0] = item_ff.b[WordBits-1] ? WordBits'(-item_ff.b) : item_ff.b;
   end

   for (genvar i = 0; i < Stages; i++) begin : g_div
      fxa_div_stage u_stage (.clock(clock), .num_i(num[i]), .rem_i(rem[i]),
         .den_i(den[i]), .num_o(num[i+1]), .rem_o(rem[i+1]), .den_o(den[i+1]));
   end

   // side pipe: stage 0 is loaded from item_ff and holds its values in the cycle after
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[Lat-2:0], item_ff.valid};
      op_pipe_ff[0] <= item_ff.opcode;
      sign_pipe_ff[0] <= {item_ff.a[WordBits-1] ^ item_ff.b[WordBits-1], item_ff.b == '0};
      sres_pipe_ff[0] <= simple_res;
      mul_pipe_ff[0] <= '0;
      for (int i = 1; i < Lat; i++) begin
         op_pipe_ff[i] <= op_pipe_ff[i-1];
         sign_pipe_ff[i] <= sign_pipe_ff[i-1];
         sres_pipe_ff[i] <= (i == 1) ? simple_res : sres_pipe_ff[i-1];
         mul_pipe_ff[i] <= (i == 1) ? mul_sat : mul_pipe_ff[i-1];
      end
   end

   // final: round/sign/clamp quotient (num[Stages] is the output of the last divider stage)
   result_type out_in, out_ff;
   logic [NumBits:0] qr;
   logic [WordBits:0] r2;
   logic signed [2*WordBits+1:0] qs;
   logic [WordBits:0] qcl;
   localparam int Dx = Stages - 1; // side-pipe index aligned with divider output

   always_comb begin
      r2 = rem[Stages];
      qr = (NumBits+1)'(num[Stages]);
      if ((WordBits+1)'(r2) >= (WordBits+1)'(den[Stages]) - r2) qr = qr + (NumBits+1)'(1);
      qs = sign_pipe_ff[Dx][1] ? -(2*WordBits+2)'(qr) : (2*WordBits+2)'(qr);
      qcl = clamp_word(qs);
      out_in = '0;
      out_in.valid = valid_ff[Dx];
      unique case (op_pipe_ff[Dx])
         OP_MUL: begin
            out_in.value = mul_pipe_ff[Dx][WordBits-1:0];
            out_in.status = mul_pipe_ff[Dx][WordBits] ? ST_SAT : ST_OK;
         end
         OP_DIV: begin
            if (sign_pipe_ff[Dx][0]) out_in.status = ST_DIVZ;
            else begin
               out_in.value = qcl[WordBits-1:0];
               out_in.status = qcl[WordBits] ? ST_SAT : ST_OK;
            end
         end
         default: begin
            out_in.value = sres_pipe_ff[Dx].value;
            out_in.cmp = sres_pipe_ff[Dx].cmp;
            out_in.status = sres_pipe_ff[Dx].status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff.valid <= 1'b0;
      else out_ff.valid <= out_in.valid;
      out_ff.value <= out_in.value;
      out_ff.cmp <= out_in.cmp;
      out_ff.status <= out_in.status;
   end

   assign rsp_valid = out_ff.valid;
   assign rsp_result_value = out_ff.value;
   assign rsp_compare_true = out_ff.cmp;
   assign rsp_status_code = out_ff.status;

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_code == ST_DIVZ |-> rsp_result_value == '0 && !rsp_compare_true)
      else $error("div by zero result not cleared");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      valid_ff[Dx] |=> rsp_valid) else $error("valid lost at output");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status_code != 2'd3) else $error("bad status");
endmodule
`default_nettype wire

// File: hdl/fxa_simple.sv
// Single-cycle-group ops (add/sub/compare/min/max/inc/dec/shifts), registered
// so they line up with the multiplier's product register. Depends on fxa_pkg.
`default_nettype none
module fxa_simple (
   input  wire logic            clock,
   input  wire fxa_pkg::item_type in_item,
   output fxa_pkg::result_type   out_res
);
   import fxa_pkg::*;
   result_type res_in, res_ff;
   logic signed [2*WordBits+1:0] a_x, b_x, sum;
   logic [WordBits:0] cl;

   always_comb begin
      a_x = (2*WordBits+2)'(in_item.a);
      b_x = (2*WordBits+2)'(in_item.b);
      res_in = '0;
      res_in.valid = in_item.valid;
      sum = '0;
      cl = '0;
      case (in_item.opcode)
         OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_FROMINT: begin
            case (in_item.opcode)
               OP_ADD:  sum = a_x + b_x;
               OP_SUB:  sum = a_x - b_x;
               OP_INC:  sum = a_x + (2*WordBits+2)'(1);
               OP_DEC:  sum = a_x - (2*WordBits+2)'(1);
               default: sum = a_x <<< FracBits;
            endcase
            cl = clamp_word(sum);
            res_in.value = cl[WordBits-1:0];
            res_in.status = cl[WordBits] ? ST_SAT : ST_OK;
         end
         OP_GT: res_in.cmp = in_item.a > in_item.b;
         OP_LT: res_in.cmp = in_item.a < in_item.b;
         OP_GE: res_in.cmp = in_item.a >= in_item.b;
         OP_LE: res_in.cmp = in_item.a <= in_item.b;
         OP_EQ: res_in.cmp = in_item.a == in_item.b;
         OP_NE: res_in.cmp = in_item.a != in_item.b;
         OP_MIN: res_in.value = (in_item.a < in_item.b) ? in_item.a : in_item.b;
         OP_MAX: res_in.value = (in_item.a > in_item.b) ? in_item.a : in_item.b;
         OP_TOINT: res_in.value = in_item.a >>> FracBits;
         default: res_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) res_ff <= res_in;
   assign out_res = res_ff;
endmodule
`default_nettype wire

// File: hdl/fxa_mul.sv
// Pipelined rounded multiply: product, magnitude round, sign and clamp.
// Depends on fxa_pkg.
`default_nettype none
module fxa_mul (
   input  wire logic            clock,
   input  wire logic signed [fxa_pkg::WordBits-1:0] a,
   input  wire logic signed [fxa_pkg::WordBits-1:0] b,
   output logic [fxa_pkg::WordBits:0]               sat_value
);
   import fxa_pkg::*;
   logic signed [2*WordBits-1:0] prod_ff;
   logic [2*WordBits-1:0] mag;
   logic signed [2*WordBits+1:0] q_s;
   logic [2*WordBits-1:0] q;

   always_ff @(posedge clock) prod_ff <= a * b;

   always_comb begin
      mag = prod_ff[2*WordBits-1] ? (2*WordBits)'(-prod_ff) : prod_ff;
      q = (mag + (2*WordBits)'((64'd1 << FracBits) >> 1)) >> FracBits;
      q_s = prod_ff[2*WordBits-1] ? -(2*WordBits+2)'(q) : (2*WordBits+2)'(q);
      sat_value = clamp_word(q_s);
   end
endmodule
`default_nettype wire

// File: hdl/fxa_div_stage.sv
// One restoring-division step: one quotient bit per stage, divisor carried.
// Depends on fxa_pkg.
`default_nettype none
module fxa_div_stage (
   input  wire logic                         clock,
   input  wire logic [fxa_pkg::NumBits-1:0]  num_i,
   input  wire logic [fxa_pkg::WordBits:0]   rem_i,
   input  wire logic [fxa_pkg::WordBits-1:0] den_i,
   output logic [fxa_pkg::NumBits-1:0]       num_o,
   output logic [fxa_pkg::WordBits:0]        rem_o,
   output logic [fxa_pkg::WordBits-1:0]      den_o
);
   import fxa_pkg::*;
   logic [WordBits+1:0] trial;
   logic [WordBits:0] rem_in;
   logic [NumBits-1:0] num_in;

   // num holds remaining dividend bits at top, quotient shifts in at bottom
   always_comb begin
      trial = {rem_i, num_i[NumBits-1]} - {2'b00, den_i};
      if (!trial[WordBits+1]) begin
         rem_in = trial[WordBits:0];
         num_in = {num_i[NumBits-2:0], 1'b1};
      end else begin
         rem_in = {rem_i[WordBits-1:0], num_i[NumBits-1]};
         num_in = {num_i[NumBits-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      num_o <= num_in;
      rem_o <= rem_in;
      den_o <= den_i;
   end
endmodule
`default_nettype wire

// File: sim/alu_checker.sv
// Result checker for the Q24.8 fixed-point ALU: predicts each accepted word
// and compares results in order. Depends on fxa_pkg.
`timescale 1ns / 100ps
module alu_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [3:0]  req_opcode,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   input  wire logic        rsp_valid,
   input  wire logic signed [31:0] rsp_result_value,
   input  wire logic        rsp_compare_true,
   input  wire logic [1:0]  rsp_status_code,
   output int               fail_count,
   output int               pending_count,
   output int               result_count
);
   import fxa_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic        cmp;
      status_type  status;
   } alu_result_type;

   alu_result_type expected_q[$];

   function automatic alu_result_type clamp64(longint v);
      alu_result_type r;
      r.cmp = 1'b0;
      r.status = ST_OK;
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647;
         r.status = ST_SAT;
      end else if (v < -64'sd2147483648) begin
         v = -64'sd2147483648;
         r.status = ST_SAT;
      end
      r.value = v[31:0];
      return r;
   endfunction

   function automatic alu_result_type alu_compute(opcode_type op, longint a, longint b);
      alu_result_type r;
      longint unsigned mag, num, den, q, rem;
      longint p;
      r.value = '0;
      r.cmp = 1'b0;
      r.status = ST_OK;
      case (op)
         OP_ADD: r = clamp64(a + b);
         OP_SUB: r = clamp64(a - b);
         OP_MUL: begin
            p = a * b;
            mag = (p < 0) ? -p : p;
            q = (mag + 128) >> 8;
            r = clamp64((p < 0) ? -longint'(q) : longint'(q));
         end
         OP_DIV: begin
            if (b == 0) begin
               r.status = ST_DIVZ;
            end else begin
               num = ((a < 0) ? -a : a) << 8;
               den = (b < 0) ? -b : b;
               q = num / den;
               rem = num % den;
               if (rem >= den - rem) q++;
               r = clamp64(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
            end
         end
         OP_GT: r.cmp = a > b;
         OP_LT: r.cmp = a < b;
         OP_GE: r.cmp = a >= b;
         OP_LE: r.cmp = a <= b;
         OP_EQ: r.cmp = a == b;
         OP_NE: r.cmp = a != b;
         OP_MIN: r.value = (a < b) ? a[31:0] : b[31:0];
         OP_MAX: r.value = (a > b) ? a[31:0] : b[31:0];
         OP_INC: r = clamp64(a + 1);
         OP_DEC: r = clamp64(a - 1);
         OP_TOINT: r.value = 32'(a >>> 8);
         default: r = clamp64(a * 256);
      endcase
      return r;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      alu_result_type e;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               $error("unexpected result word value=%0d", rsp_result_value);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_result_value !== e.value || rsp_compare_true !== e.cmp ||
                   rsp_status_code !== e.status) begin
                  fail_count <= fail_count + 1;
                  if (rsp_result_value !== e.value)
                     $error("result_value expected %0d actual %0d",
                            $signed(e.value), rsp_result_value);
                  if (rsp_compare_true !== e.cmp)
                     $error("compare_true expected %0b actual %0b", e.cmp,
                            rsp_compare_true);
                  if (rsp_status_code !== e.status)
                     $error("status_code expected %0d actual %0d", e.status,
                            rsp_status_code);
               end
            end
         end
         if (start && !busy)
            expected_q.push_back(alu_compute(opcode_type'(req_opcode),
                                             longint'(req_operand_a),
                                             longint'(req_operand_b)));
      end
   end
endmodule

// File: sim/tb_top.sv
// Testbench top for fixed_point_q8_alu_core: drives directed and random words
// with random gaps and gives the verdict. Depends on fxa_pkg and alu_checker.
`timescale 1ns / 100ps
module tb_top;
   import fxa_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [3:0] req_opcode = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic rsp_compare_true;
   logic [1:0] rsp_status_code;
   int fail_count, pending_count, result_count;
   int word_count = 0;

   always #5 clock = ~clock;

   fixed_point_q8_alu_core dut (.*);
   alu_checker checker_i (.*);

   task automatic send_word(opcode_type op, logic [31:0] a, logic [31:0] b, int gap);
      start <= 1'b1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (busy);
      word_count++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Operand mix: extremes, small values, near-zero divisors, full random.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 8) - 4;
         3: return $urandom_range(0, 1023) - 512;
         4: return $urandom_range(0, 131071) - 65536;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int gap;
      logic [31:0] a, b;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: every opcode on extremes, ties, divide by zero, rounding ties
      for (int op = 0; op < 16; op++)
         send_word(opcode_type'(op), 32'h80000000, 32'h7fffffff, 0);
      send_word(OP_DIV, 32'h00000100, 32'h00000000, 0);
      send_word(OP_MUL, 32'h00000180, 32'h00000080, 1);
      send_word(OP_MUL, 32'hfffffe80, 32'h00000080, 0);
      send_word(OP_DIV, 32'h00000001, 32'h00000200, 0);
      send_word(OP_DIV, 32'h7fffffff, 32'h00000001, 2);
      send_word(OP_MIN, 32'h00000005, 32'h00000005, 0);
      send_word(OP_MAX, 32'hffffffff, 32'hffffffff, 0);
      send_word(OP_TOINT, 32'hffffff01, 32'h0, 0);
      send_word(OP_INC, 32'h7fffffff, 32'h0, 0);
      for (int i = 0; i < 1800; i++) begin
         a = pick_operand();
         b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
         gap = ((i / 200) % 2 == 0) ? $urandom_range(0, 15) : 0;
         send_word(opcode_type'($urandom_range(0, 15)), a, b, gap);
      end
      start <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d words sent, %0d results checked over all 16 opcodes",
               word_count, result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_top failed");
      $finish;
   end
endmodule

// File: filelist.f
hdl/fxa_pkg.sv
hdl/fxa_simple.sv
hdl/fxa_mul.sv
hdl/fxa_div_stage.sv
hdl/fixed_point_q8_alu_core.sv
sim/alu_checker.sv
sim/tb_top.sv
